FILE: design/bbph_pkg.sv
`default_nettype none

package bbph_pkg;

    // default configuration of the sample path
    localparam int SAMPLE_BITS_DEF    = 12;
    localparam int COEF_FRAC_BITS_DEF = 16;

    // fixed field widths
    localparam int COEF_W     = 18;
    localparam int Y_W        = 31;
    localparam int PEAK_W     = 30;
    localparam int COUNT_W    = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 18;

    // register map
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4,
        REG_DC = 3'd5
    } cfg_reg_t;

    // coefficient defaults: band-pass section, 16 fraction bits
    localparam logic signed [COEF_W-1:0] B0_RESET = 18'sd4027;
    localparam logic signed [COEF_W-1:0] B1_RESET = 18'sd0;
    localparam logic signed [COEF_W-1:0] B2_RESET = -18'sd4027;
    localparam logic signed [COEF_W-1:0] A1_RESET = -18'sd122038;
    localparam logic signed [COEF_W-1:0] A2_RESET = 18'sd57482;
    localparam int                       DC_OFFSET_RESET = 2234;

    // output saturation limits
    localparam logic signed [Y_W-1:0] Y_MAX = {1'b0, {(Y_W-1){1'b1}}};
    localparam logic signed [Y_W-1:0] Y_MIN = {1'b1, {(Y_W-1){1'b0}}};

    // full coefficient set shared by both arithmetic stages
    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
    } coef_set_t;

endpackage

`default_nettype wire

FILE: design/bbph_regs.sv
`default_nettype none

module bbph_regs
    import bbph_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wr_data,
    output coef_set_t                   coef,
    output logic      [SAMPLE_BITS-1:0] dc_offset
);

    coef_set_t              coef_reg;
    logic [SAMPLE_BITS-1:0] dc_offset_reg;

    // register file, writes outside the map are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg.b0   <= B0_RESET;
            coef_reg.b1   <= B1_RESET;
            coef_reg.b2   <= B2_RESET;
            coef_reg.a1   <= A1_RESET;
            coef_reg.a2   <= A2_RESET;
            dc_offset_reg <= SAMPLE_BITS'(DC_OFFSET_RESET);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_B0: coef_reg.b0 <= cfg_wr_data[COEF_W-1:0];
                REG_B1: coef_reg.b1 <= cfg_wr_data[COEF_W-1:0];
                REG_B2: coef_reg.b2 <= cfg_wr_data[COEF_W-1:0];
                REG_A1: coef_reg.a1 <= cfg_wr_data[COEF_W-1:0];
                REG_A2: coef_reg.a2 <= cfg_wr_data[COEF_W-1:0];
                REG_DC: dc_offset_reg <= cfg_wr_data[SAMPLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign coef      = coef_reg;
    assign dc_offset = dc_offset_reg;

endmodule

`default_nettype wire

FILE: design/bbph_ff.sv
`default_nettype none

module bbph_ff
    import bbph_pkg::*;
#(
    parameter  int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int X_W         = SAMPLE_BITS + 1,
    localparam int FF_W        = COEF_W + X_W + 2
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [SAMPLE_BITS-1:0]  adc_sample,
    input  wire logic [SAMPLE_BITS-1:0]  dc_offset,
    input  wire coef_set_t               coef,
    output logic                         ff_valid,
    input  wire logic                    ff_ready,
    output logic signed [FF_W-1:0]       ff_sum
);

    localparam int PROD_W = COEF_W + X_W;

    logic                     accept;
    logic signed [X_W-1:0]    x_cent;
    logic signed [PROD_W-1:0] prod0;
    logic signed [PROD_W-1:0] prod1;
    logic signed [PROD_W-1:0] prod2;
    logic signed [FF_W-1:0]   ff_next;
    logic signed [X_W-1:0]    x_hist1_reg;
    logic signed [X_W-1:0]    x_hist2_reg;
    logic signed [FF_W-1:0]   ff_reg;
    logic                     valid_reg;

    // stage is free when empty or when its content moves on
    assign in_ready = !valid_reg || ff_ready;
    assign accept   = in_valid && in_ready;

    // center the raw sample
    assign x_cent = signed'({1'b0, adc_sample}) - signed'({1'b0, dc_offset});

    // feed-forward taps
    assign prod0   = PROD_W'(coef.b0) * PROD_W'(x_cent);
    assign prod1   = PROD_W'(coef.b1) * PROD_W'(x_hist1_reg);
    assign prod2   = PROD_W'(coef.b2) * PROD_W'(x_hist2_reg);
    assign ff_next = FF_W'(prod0) + FF_W'(prod1) + FF_W'(prod2);

    // input history and valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            x_hist1_reg <= '0;
            x_hist2_reg <= '0;
        end else begin
            if (accept) begin
                valid_reg   <= 1'b1;
                x_hist1_reg <= x_cent;
                x_hist2_reg <= x_hist1_reg;
            end else if (ff_ready) begin
                valid_reg   <= 1'b0;
            end
        end
    end

    // feed-forward sum register
    always_ff @(posedge aclk) begin
        if (accept) begin
            ff_reg <= ff_next;
        end
    end

    assign ff_valid = valid_reg;
    assign ff_sum   = ff_reg;

    // history only moves on an accepted request
    a_hist_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> x_hist2_reg == $past(x_hist1_reg))
        else $error("input history did not shift");

endmodule

`default_nettype wire

FILE: design/bbph_fb.sv
`default_nettype none

module bbph_fb
    import bbph_pkg::*;
#(
    parameter  int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter  int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
    localparam int FF_W           = COEF_W + SAMPLE_BITS + 3
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  ff_valid,
    output logic                       ff_ready,
    input  wire logic signed [FF_W-1:0] ff_sum,
    input  wire coef_set_t             coef,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic signed [Y_W-1:0]      filtered,
    output logic        [PEAK_W-1:0]   peak,
    output logic        [COUNT_W-1:0]  sample_count
);

    localparam int FFS_W  = FF_W + COEF_FRAC_BITS;
    localparam int PFB_W  = COEF_W + Y_W;
    localparam int ACC_W  = ((FFS_W > PFB_W) ? FFS_W : PFB_W) + 2;
    localparam int SUM_W  = ACC_W + 1;
    localparam int QR_W   = SUM_W - COEF_FRAC_BITS;
    localparam int Q_W    = (QR_W > Y_W + 1) ? QR_W : Y_W + 1;
    localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) << (COEF_FRAC_BITS - 1);

    logic                      load;
    logic signed [ACC_W-1:0]   fb1;
    logic signed [ACC_W-1:0]   fb2;
    logic signed [ACC_W-1:0]   acc;
    logic signed [SUM_W-1:0]   rnd;
    logic signed [Q_W-1:0]     q;
    logic signed [Y_W-1:0]     y_next;
    logic        [PEAK_W-1:0]  peak_next;
    logic signed [Y_W-1:0]     y_prev1_reg;
    logic signed [Y_W-1:0]     y_prev2_reg;
    logic        [PEAK_W-1:0]  peak_reg;
    logic        [COUNT_W-1:0] count_reg;
    logic                      m_valid_reg;

    // result register takes a new value when empty or being drained
    assign ff_ready = !m_valid_reg || m_ready;
    assign load     = ff_valid && ff_ready;

    // feedback taps and accumulator at 2F fraction bits
    assign fb1 = ACC_W'(coef.a1) * ACC_W'(y_prev1_reg);
    assign fb2 = ACC_W'(coef.a2) * ACC_W'(y_prev2_reg);
    assign acc = (ACC_W'(ff_sum) <<< COEF_FRAC_BITS) - fb1 - fb2;

    // round half up, back to F fraction bits
    assign rnd = SUM_W'(acc) + RND_HALF;
    assign q   = Q_W'(rnd >>> COEF_FRAC_BITS);

    // saturate to the output range
    always_comb begin
        if (q > Q_W'(Y_MAX)) begin
            y_next = Y_MAX;
        end else if (q < Q_W'(Y_MIN)) begin
            y_next = Y_MIN;
        end else begin
            y_next = q[Y_W-1:0];
        end
    end

    // peak only rises on a strictly larger positive output
    assign peak_next = (!y_next[Y_W-1] && (y_next[PEAK_W-1:0] > peak_reg)) ?
                       y_next[PEAK_W-1:0] : peak_reg;

    // output history, peak, counter; these also form the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            y_prev1_reg <= '0;
            y_prev2_reg <= '0;
            peak_reg    <= '0;
            count_reg   <= '0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                y_prev1_reg <= y_next;
                y_prev2_reg <= y_prev1_reg;
                peak_reg    <= peak_next;
                count_reg   <= count_reg + COUNT_W'(1);
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign filtered     = y_prev1_reg;
    assign peak         = peak_reg;
    assign sample_count = count_reg;

    // peak never falls
    a_peak_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> peak_reg >= $past(peak_reg))
        else $error("peak decreased");

    // one count per result
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> count_reg == COUNT_W'($past(count_reg) + COUNT_W'(1)))
        else $error("sample counter did not advance by one");

    // output history shifts with each result
    a_y_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> y_prev2_reg == $past(y_prev1_reg))
        else $error("output history did not shift");

    // a stalled result keeps its fields
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !load |=> $stable(count_reg) && $stable(y_prev1_reg) && $stable(peak_reg))
        else $error("result changed without a new request");

endmodule

`default_nettype wire

FILE: design/bandpass_biquad_peak_hold.sv
// an input request passes the feed-forward sum register and then the result register to reach m_axis
// throughput: one request per cycle while m_axis_tready is high; the recursive path
// (two feedback multipliers, the accumulator add, rounding and saturation) is combinational
// reset: synchronous, active low; clears sample and output history, peak,
// counter and both valid flags, and loads the default coefficients and offset
`default_nettype none

module bandpass_biquad_peak_hold
    import bbph_pkg::*;
#(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  wire logic                                        aclk,
    input  wire logic                                        aresetn,
    // configuration
    input  wire logic                                        cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0]                       cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]                       cfg_wr_data,
    // sample stream
    input  wire logic                                        s_axis_tvalid,
    output logic                                             s_axis_tready,
    // adc_sample, zero padded to whole bytes
    input  wire logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]    s_axis_tdata,
    // result stream
    output logic                                             m_axis_tvalid,
    input  wire logic                                        m_axis_tready,
    // filtered[30:0], peak[60:31], sample_count[92:61], zero pad
    output logic [((Y_W + PEAK_W + COUNT_W + 7) / 8) * 8 - 1:0] m_axis_tdata
);

    localparam int OUT_TDATA_W = ((Y_W + PEAK_W + COUNT_W + 7) / 8) * 8;
    localparam int FF_W        = COEF_W + SAMPLE_BITS + 3;

    coef_set_t                coef;
    logic [SAMPLE_BITS-1:0]   dc_offset;
    logic                     ff_valid;
    logic                     ff_ready;
    logic signed [FF_W-1:0]   ff_sum;
    logic signed [Y_W-1:0]    filtered;
    logic        [PEAK_W-1:0] peak;
    logic        [COUNT_W-1:0] sample_count;

    // configuration registers
    bbph_regs #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .coef        (coef),
        .dc_offset   (dc_offset)
    );

    // offset removal and feed-forward stage
    bbph_ff #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ff (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .adc_sample (s_axis_tdata[SAMPLE_BITS-1:0]),
        .dc_offset  (dc_offset),
        .coef       (coef),
        .ff_valid   (ff_valid),
        .ff_ready   (ff_ready),
        .ff_sum     (ff_sum)
    );

    // feedback, rounding, saturation and result register
    bbph_fb #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_fb (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ff_valid     (ff_valid),
        .ff_ready     (ff_ready),
        .ff_sum       (ff_sum),
        .coef         (coef),
        .m_valid      (m_axis_tvalid),
        .m_ready      (m_axis_tready),
        .filtered     (filtered),
        .peak         (peak),
        .sample_count (sample_count)
    );

    // pack result fields, lowest field first
    assign m_axis_tdata = OUT_TDATA_W'({sample_count, peak, filtered});

endmodule

`default_nettype wire

FILE: test/tb_bandpass_biquad_peak_hold.sv
`default_nettype none

module tb_bandpass_biquad_peak_hold
    import bbph_pkg::*;
;

    localparam int SB   = SAMPLE_BITS_DEF;
    localparam int FRAC = COEF_FRAC_BITS_DEF;
    localparam int S_W  = ((SB + 7) / 8) * 8;
    localparam int M_W  = ((Y_W + PEAK_W + COUNT_W + 7) / 8) * 8;

    // indexes past the register map, writes there must be dropped
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int COEF_MAX = 131071;
    localparam int COEF_MIN = -131072;
    localparam int ADC_MAX  = 4095;

    typedef struct packed {
        logic [COUNT_W-1:0]       count;
        logic [PEAK_W-1:0]        peak;
        logic signed [Y_W-1:0]    filtered;
    } biquad_out_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // adc_sample, zero pad
    logic [S_W-1:0]         s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // filtered, peak, sample_count, zero pad
    logic [M_W-1:0]         m_axis_tdata;

    bandpass_biquad_peak_hold dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // filter coefficients and offset as the block should hold them
    logic signed [COEF_W-1:0] k_b0 = B0_RESET;
    logic signed [COEF_W-1:0] k_b1 = B1_RESET;
    logic signed [COEF_W-1:0] k_b2 = B2_RESET;
    logic signed [COEF_W-1:0] k_a1 = A1_RESET;
    logic signed [COEF_W-1:0] k_a2 = A2_RESET;
    logic [SB-1:0]            adc_offset = SB'(DC_OFFSET_RESET);

    // filter history, peak and sample count
    logic signed [SB:0]       xd1 = '0;
    logic signed [SB:0]       xd2 = '0;
    logic signed [Y_W-1:0]    yd1 = '0;
    logic signed [Y_W-1:0]    yd2 = '0;
    logic [PEAK_W-1:0]        peak_hold = '0;
    logic [COUNT_W-1:0]       n_filtered = '0;

    logic [SB-1:0]  adc_backlog[$];
    biquad_out_t    want_results[$];

    int  n_queued = 0;
    int  n_accepted = 0;
    int  fail_count = 0;
    bit  sample_taken = 1'b0;
    bit  result_taken = 1'b0;
    int  tx_gap = 0;
    int  tx_calm = 0;
    int  rx_wait = 0;
    int  rx_calm = 0;
    int  long_hold_left = 0;
    bit  long_hold_done = 1'b0;

    // one biquad step with rounding, saturation and peak tracking
    function automatic biquad_out_t biquad_step(input logic [SB-1:0] raw);
        longint      x;
        longint      ff;
        longint      acc;
        longint      y;
        biquad_out_t r;
        x   = longint'(raw) - longint'(adc_offset);
        ff  = longint'(k_b0) * x + longint'(k_b1) * longint'(xd1)
            + longint'(k_b2) * longint'(xd2);
        acc = ff * (longint'(1) <<< FRAC) - longint'(k_a1) * longint'(yd1)
            - longint'(k_a2) * longint'(yd2);
        y   = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
        if (y > longint'(Y_MAX))
            y = longint'(Y_MAX);
        if (y < longint'(Y_MIN))
            y = longint'(Y_MIN);
        n_filtered = n_filtered + 1'b1;
        xd2 = xd1;
        xd1 = x[SB:0];
        yd2 = yd1;
        yd1 = y[Y_W-1:0];
        if (y > longint'(peak_hold))
            peak_hold = y[PEAK_W-1:0];
        r.filtered = y[Y_W-1:0];
        r.peak     = peak_hold;
        r.count    = n_filtered;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input longint want, input longint got);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch %s: expected %0d, got %0d", what, want, got);
    endtask

    // input request tracking, prediction and result checking
    always @(posedge aclk) begin
        biquad_out_t want;
        biquad_out_t got;
        if (!aresetn) begin
            sample_taken = 1'b0;
            result_taken = 1'b0;
        end else begin
            sample_taken = s_axis_tvalid && s_axis_tready;
            result_taken = m_axis_tvalid && m_axis_tready;
            if (sample_taken) begin
                want_results.push_back(biquad_step(s_axis_tdata[SB-1:0]));
                n_accepted++;
            end
            if (result_taken) begin
                got.filtered = m_axis_tdata[Y_W-1:0];
                got.peak     = m_axis_tdata[Y_W+PEAK_W-1:Y_W];
                got.count    = m_axis_tdata[Y_W+PEAK_W+COUNT_W-1:Y_W+PEAK_W];
                if (want_results.size() == 0) begin
                    note_mismatch("unexpected result, count", -1, longint'(got.count));
                end else begin
                    want = want_results.pop_front();
                    if (got.filtered !== want.filtered)
                        note_mismatch("filtered", longint'(want.filtered),
                                      longint'(got.filtered));
                    if (got.peak !== want.peak)
                        note_mismatch("peak", longint'(want.peak), longint'(got.peak));
                    if (got.count !== want.count)
                        note_mismatch("sample_count", longint'(want.count),
                                      longint'(got.count));
                end
            end
        end
    end

    // sample driver, random gaps between requests
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !sample_taken) begin
            // request still waiting for tready
        end else if (tx_gap > 0) begin
            tx_gap--;
            s_axis_tvalid <= 1'b0;
        end else if (adc_backlog.size() > 0) begin
            s_axis_tdata  <= {{(S_W-SB){1'b0}}, adc_backlog.pop_front()};
            s_axis_tvalid <= 1'b1;
            if (tx_calm > 0) begin
                tx_calm--;
                tx_gap = 0;
            end else if ($urandom_range(0, 15) == 0) begin
                tx_calm = $urandom_range(8, 40);
                tx_gap  = 0;
            end else begin
                tx_gap = $urandom_range(0, 7);
            end
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // result receiver, random stalls plus one long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (long_hold_left > 0) begin
            long_hold_left--;
            m_axis_tready <= 1'b0;
        end else if (!long_hold_done && n_accepted >= 500) begin
            long_hold_done = 1'b1;
            long_hold_left = 300;
            m_axis_tready <= 1'b0;
        end else begin
            if (result_taken) begin
                if (rx_calm > 0) begin
                    rx_calm--;
                    rx_wait = 0;
                end else if ($urandom_range(0, 15) == 0) begin
                    rx_calm = $urandom_range(8, 40);
                    rx_wait = 0;
                end else begin
                    rx_wait = $urandom_range(0, 7);
                end
            end
            if (rx_wait > 0) begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // register write, mirrored into the predictor
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        case (idx)
            REG_B0:  k_b0 = val[COEF_W-1:0];
            REG_B1:  k_b1 = val[COEF_W-1:0];
            REG_B2:  k_b2 = val[COEF_W-1:0];
            REG_A1:  k_a1 = val[COEF_W-1:0];
            REG_A2:  k_a2 = val[COEF_W-1:0];
            REG_DC:  adc_offset = val[SB-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_filter(input int b0, input int b1, input int b2,
                               input int a1, input int a2, input int dc);
        write_reg(REG_B0, CFG_DATA_W'(b0));
        write_reg(REG_B1, CFG_DATA_W'(b1));
        write_reg(REG_B2, CFG_DATA_W'(b2));
        write_reg(REG_A1, CFG_DATA_W'(a1));
        write_reg(REG_A2, CFG_DATA_W'(a2));
        write_reg(REG_DC, CFG_DATA_W'(dc));
    endtask

    task automatic queue_sample(input logic [SB-1:0] v);
        adc_backlog.push_back(v);
        n_queued++;
    endtask

    // random samples, weighted toward the rails
    task automatic queue_random(input int n);
        int i;
        for (i = 0; i < n; i++) begin
            case ($urandom_range(0, 7))
                0:       queue_sample('0);
                1:       queue_sample(SB'(ADC_MAX));
                default: queue_sample(SB'($urandom_range(0, ADC_MAX)));
            endcase
        end
    endtask

    // wait until every request is taken and every result is back
    task automatic drain();
        while (n_accepted != n_queued || want_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // run limit
    initial begin
        #(12 * 400000);
        $display("TB_ERROR");
        $finish;
    end

    // stimulus sequence
    initial begin
        int ph;
        int a1;
        int a2;
        int lim;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // default band-pass: rails, zero input, small steps around the offset
        queue_sample('0);
        queue_sample(SB'(ADC_MAX));
        queue_sample(SB'(ADC_MAX));
        queue_sample(SB'(DC_OFFSET_RESET));
        queue_sample(SB'(DC_OFFSET_RESET + 1));
        queue_sample(SB'(DC_OFFSET_RESET - 1));
        queue_sample('0);
        queue_sample('0);
        queue_sample(SB'(ADC_MAX));
        queue_sample(12'hAAA);
        queue_sample(12'h555);
        queue_sample(SB'(DC_OFFSET_RESET));
        drain();

        // writes past the register map change nothing
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
        queue_sample(SB'(ADC_MAX));
        queue_sample('0);
        queue_random(300);
        drain();

        // random stable sections, pole radius kept inside the unit circle
        for (ph = 0; ph < 3; ph++) begin
            a2  = int'($urandom_range(0, 120000)) - 60000;
            lim = 65536 + a2 - 2000;
            a1  = int'($urandom_range(0, 2 * lim)) - lim;
            load_filter(int'($urandom_range(0, 262143)) + COEF_MIN,
                        int'($urandom_range(0, 262143)) + COEF_MIN,
                        int'($urandom_range(0, 262143)) + COEF_MIN,
                        a1, a2, int'($urandom_range(0, ADC_MAX)));
            queue_random(280);
            drain();
        end

        // largest gain, rails drive the output into positive saturation;
        // offset written with the upper data bits set
        load_filter(COEF_MAX, COEF_MAX, COEF_MAX, 0, 0, 0);
        write_reg(REG_DC, 18'h3F000);
        queue_sample(SB'(ADC_MAX));
        queue_sample(SB'(ADC_MAX));
        queue_sample(SB'(ADC_MAX));
        drain();

        // largest offset, zero input saturates negative
        write_reg(REG_DC, 18'h3FFFF);
        queue_sample('0);
        queue_sample('0);
        queue_sample('0);
        drain();

        // unstable extremes of the feedback terms
        load_filter(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX,
                    int'($urandom_range(0, ADC_MAX)));
        queue_random(200);
        drain();
        load_filter(int'($urandom_range(0, 262143)) + COEF_MIN, COEF_MAX, COEF_MIN,
                    COEF_MAX, COEF_MIN, int'($urandom_range(0, ADC_MAX)));
        queue_random(200);
        drain();

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
design/bbph_pkg.sv
design/bbph_regs.sv
design/bbph_ff.sv
design/bbph_fb.sv
design/bandpass_biquad_peak_hold.sv
test/tb_bandpass_biquad_peak_hold.sv
